>>> sv/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types, widths and angle constants of the rectangular to polar core.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int ANGLE_W      = 16;
  localparam int ANG_FRAC     = 61;
  localparam int OUT_FRAC     = 13;
  localparam int CORDIC_STEPS = 62;
  localparam int NORM_STEPS   = 6;

  typedef struct packed {
    logic zero;    // both parts zero
    logic re_neg;
    logic im_neg;
    logic sw;      // |im| > |re|: octant angle taken from the swapped pair
    logic yzero;   // smaller part is zero
    logic yeqx;    // equal absolute parts
  } flags_t;

  // atan(1/5) and atan(1/239) in Q61, truncating series terms
  function automatic logic [63:0] atan_r5();
    logic [63:0] p;
    logic [63:0] acc;
    p = (64'd1 << 61) / 5;
    acc = p;
    p = p / 25; acc = acc - p / 3;
    p = p / 25; acc = acc + p / 5;
    p = p / 25; acc = acc - p / 7;
    p = p / 25; acc = acc + p / 9;
    p = p / 25; acc = acc - p / 11;
    p = p / 25; acc = acc + p / 13;
    p = p / 25; acc = acc - p / 15;
    p = p / 25; acc = acc + p / 17;
    p = p / 25; acc = acc - p / 19;
    p = p / 25; acc = acc + p / 21;
    p = p / 25; acc = acc - p / 23;
    p = p / 25; acc = acc + p / 25;
    p = p / 25; acc = acc - p / 27;
    p = p / 25; acc = acc + p / 29;
    return acc;
  endfunction

  function automatic logic [63:0] atan_r239();
    logic [63:0] p;
    logic [63:0] acc;
    p = (64'd1 << 61) / 239;
    acc = p;
    p = p / 57121; acc = acc - p / 3;
    p = p / 57121; acc = acc + p / 5;
    p = p / 57121; acc = acc - p / 7;
    p = p / 57121; acc = acc + p / 9;
    return acc;
  endfunction

  localparam logic [63:0] QUARTER_PI = 64'd4 * atan_r5() - atan_r239();
  localparam logic [63:0] HALF_PI    = 64'd2 * QUARTER_PI;
  localparam logic [63:0] FULL_PI    = 64'd4 * QUARTER_PI;

  // atan(2^-i) in Q61; step zero uses the QUARTER_PI constant, atan(1) = pi/4
  function automatic logic [63:0] atan_tab(input int i);
    logic [63:0] acc;
    acc = 64'd0;
    if (i == 0) begin
      acc = QUARTER_PI;
    end else begin
      if (i * 1  <= 61) acc = acc + (64'd1 << (61 - i * 1 )) / 1;
      if (i * 3  <= 61) acc = acc - (64'd1 << (61 - i * 3 )) / 3;
      if (i * 5  <= 61) acc = acc + (64'd1 << (61 - i * 5 )) / 5;
      if (i * 7  <= 61) acc = acc - (64'd1 << (61 - i * 7 )) / 7;
      if (i * 9  <= 61) acc = acc + (64'd1 << (61 - i * 9 )) / 9;
      if (i * 11 <= 61) acc = acc - (64'd1 << (61 - i * 11)) / 11;
      if (i * 13 <= 61) acc = acc + (64'd1 << (61 - i * 13)) / 13;
      if (i * 15 <= 61) acc = acc - (64'd1 << (61 - i * 15)) / 15;
      if (i * 17 <= 61) acc = acc + (64'd1 << (61 - i * 17)) / 17;
      if (i * 19 <= 61) acc = acc - (64'd1 << (61 - i * 19)) / 19;
      if (i * 21 <= 61) acc = acc + (64'd1 << (61 - i * 21)) / 21;
      if (i * 23 <= 61) acc = acc - (64'd1 << (61 - i * 23)) / 23;
      if (i * 25 <= 61) acc = acc + (64'd1 << (61 - i * 25)) / 25;
      if (i * 27 <= 61) acc = acc - (64'd1 << (61 - i * 27)) / 27;
      if (i * 29 <= 61) acc = acc + (64'd1 << (61 - i * 29)) / 29;
      if (i * 31 <= 61) acc = acc - (64'd1 << (61 - i * 31)) / 31;
      if (i * 33 <= 61) acc = acc + (64'd1 << (61 - i * 33)) / 33;
      if (i * 35 <= 61) acc = acc - (64'd1 << (61 - i * 35)) / 35;
      if (i * 37 <= 61) acc = acc + (64'd1 << (61 - i * 37)) / 37;
      if (i * 39 <= 61) acc = acc - (64'd1 << (61 - i * 39)) / 39;
      if (i * 41 <= 61) acc = acc + (64'd1 << (61 - i * 41)) / 41;
      if (i * 43 <= 61) acc = acc - (64'd1 << (61 - i * 43)) / 43;
      if (i * 45 <= 61) acc = acc + (64'd1 << (61 - i * 45)) / 45;
      if (i * 47 <= 61) acc = acc - (64'd1 << (61 - i * 47)) / 47;
      if (i * 49 <= 61) acc = acc + (64'd1 << (61 - i * 49)) / 49;
      if (i * 51 <= 61) acc = acc - (64'd1 << (61 - i * 51)) / 51;
      if (i * 53 <= 61) acc = acc + (64'd1 << (61 - i * 53)) / 53;
      if (i * 55 <= 61) acc = acc - (64'd1 << (61 - i * 55)) / 55;
      if (i * 57 <= 61) acc = acc + (64'd1 << (61 - i * 57)) / 57;
      if (i * 59 <= 61) acc = acc - (64'd1 << (61 - i * 59)) / 59;
      if (i * 61 <= 61) acc = acc + (64'd1 << (61 - i * 61)) / 61;
    end
    return acc;
  endfunction

  // arithmetic shift of the magnitude, sign kept (rounds toward zero)
  function automatic logic signed [63:0] shift_tz(input logic signed [63:0] v,
                                                  input int unsigned s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = m >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

>>> sv/crp_if.sv
// ----------------------------------------------------------------------------
// crp_if
// Valid/ready channels for complex samples in and polar results out.
// ----------------------------------------------------------------------------
interface crp_in_if #(
  parameter int DW = crp_pkg::DATA_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] re_part;
  logic signed [DW-1:0] im_part;

  modport source (output valid, re_part, im_part, input ready);
  modport sink   (input valid, re_part, im_part, output ready);
endinterface

interface crp_out_if #(
  parameter int DW = crp_pkg::DATA_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic [DW-1:0]                     magnitude;
  logic signed [crp_pkg::ANGLE_W-1:0] angle;
  logic                              angle_valid;

  modport source (output valid, magnitude, angle, angle_valid, input ready);
  modport sink   (input valid, magnitude, angle, angle_valid, output ready);
endinterface

>>> sv/complex_rect_to_polar_core.sv
// ----------------------------------------------------------------------------
// complex_rect_to_polar_core
// Rectangular to polar conversion: exact integer modulus and CORDIC argument.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while the result side takes items.
// Each result passes through the stages of the angle path: one input stage,
// one squaring stage, six normalization stages, 62 vectoring CORDIC stages in
// Q61, one quadrant mapping stage and the output register. The modulus runs
// alongside as a one-bit-per-stage square root. A stall on the result side
// freezes the whole pipeline; nothing is dropped or repeated. Both parts zero
// gives magnitude 0, angle 0 and angle_valid low.
module complex_rect_to_polar_core #(
  parameter int DATA_WIDTH = crp_pkg::DATA_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crp_in_if.sink    in_i,
  crp_out_if.source out_o
);

  localparam int DW       = DATA_WIDTH;
  localparam int SQW      = 2 * DW + 1;
  localparam int NRM_FST  = 2;
  localparam int NRM_LST  = NRM_FST + crp_pkg::NORM_STEPS - 1;
  localparam int SQ_FST   = 3;
  localparam int SQ_LST   = SQ_FST + DW - 1;
  localparam int CR_FST   = NRM_LST + 1;
  localparam int CR_LST   = CR_FST + crp_pkg::CORDIC_STEPS - 1;
  localparam int MAP_STG  = CR_LST + 1;
  localparam int NST      = MAP_STG + 1;
  localparam int RND_SH   = crp_pkg::ANG_FRAC - crp_pkg::OUT_FRAC;

  logic en;

  logic                  vld_q   [NST];
  crp_pkg::flags_t       flags_q [NST];
  logic signed [63:0]    cx_q    [NST];
  logic signed [63:0]    cy_q    [NST];
  logic signed [63:0]    z_q     [NST];
  logic [SQW-1:0]        n_q     [NST];
  logic [SQW-1:0]        res_q   [NST];

  logic [DW-1:0]   ax_q, ay_q;
  logic [2*DW-1:0] sqa_q, sqb_q;

  logic                               out_vld_q;
  logic [DW-1:0]                      mag_q;
  logic signed [crp_pkg::ANGLE_W-1:0] ang_q;
  logic                               aval_q;

  // advance everything together unless a finished result is held
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- stage 0: absolute values ----------------
  logic [DW-1:0]   ax_d, ay_d;
  crp_pkg::flags_t f0_d;

  always_comb begin
    ax_d = in_i.re_part[DW-1] ? DW'(-in_i.re_part) : DW'(in_i.re_part);
    ay_d = in_i.im_part[DW-1] ? DW'(-in_i.im_part) : DW'(in_i.im_part);
    f0_d        = '0;
    f0_d.zero   = (in_i.re_part == '0) && (in_i.im_part == '0);
    f0_d.re_neg = in_i.re_part[DW-1];
    f0_d.im_neg = in_i.im_part[DW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q       <= ax_d;
      ay_q       <= ay_d;
      flags_q[0] <= f0_d;
    end
  end

  // ---------------- stage 1: squares, octant swap ----------------
  crp_pkg::flags_t f1_d;
  logic [DW-1:0]   xs_d, ys_d;

  always_comb begin
    f1_d       = flags_q[0];
    f1_d.sw    = ay_q > ax_q;
    xs_d       = f1_d.sw ? ay_q : ax_q;
    ys_d       = f1_d.sw ? ax_q : ay_q;
    f1_d.yzero = ys_d == '0;
    f1_d.yeqx  = ax_q == ay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[1] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqa_q      <= ax_q * ax_q;
      sqb_q      <= ay_q * ay_q;
      flags_q[1] <= f1_d;
      cx_q[1]    <= $signed(64'(xs_d));
      cy_q[1]    <= $signed(64'(ys_d));
      z_q[1]     <= '0;
      n_q[1]     <= '0;
      res_q[1]   <= '0;
    end
  end

  // ---------------- stages 2 .. MAP_STG ----------------
  for (genvar k = 2; k < NST; k++) begin : g_stg

    // control lane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        flags_q[k] <= flags_q[k-1];
      end
    end

    // square root lane
    logic [SQW-1:0] n_d, res_d;
    if (k == NRM_FST) begin : g_sum
      always_comb begin
        n_d   = SQW'(sqa_q) + SQW'(sqb_q);
        res_d = '0;
      end
    end else if (k >= SQ_FST && k <= SQ_LST) begin : g_sq
      localparam logic [SQW-1:0] SQ_BIT =
        {{(SQW-1){1'b0}}, 1'b1} << (2 * DW - 2 - 2 * (k - SQ_FST));
      logic [SQW-1:0] trial;
      always_comb begin
        trial = res_q[k-1] + SQ_BIT;
        if (n_q[k-1] >= trial) begin
          n_d   = n_q[k-1] - trial;
          res_d = (res_q[k-1] >> 1) + SQ_BIT;
        end else begin
          n_d   = n_q[k-1];
          res_d = res_q[k-1] >> 1;
        end
      end
    end else begin : g_sqp
      always_comb begin
        n_d   = n_q[k-1];
        res_d = res_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        n_q[k]   <= n_d;
        res_q[k] <= res_d;
      end
    end

    // angle lane
    logic signed [63:0] cx_d, cy_d, z_d;
    if (k >= NRM_FST && k <= NRM_LST) begin : g_nrm
      localparam int unsigned SH = 32 >> (k - NRM_FST);
      localparam logic signed [63:0] LIM = 64'sd1 <<< (60 - SH);
      always_comb begin
        z_d = z_q[k-1];
        if (cx_q[k-1] < LIM) begin
          cx_d = cx_q[k-1] <<< SH;
          cy_d = cy_q[k-1] <<< SH;
        end else begin
          cx_d = cx_q[k-1];
          cy_d = cy_q[k-1];
        end
      end
    end else if (k >= CR_FST && k <= CR_LST) begin : g_cr
      localparam int unsigned IDX = k - CR_FST;
      localparam logic signed [63:0] ATAN = $signed(crp_pkg::atan_tab(IDX));
      logic signed [63:0] dx, dy;
      always_comb begin
        dx = crp_pkg::shift_tz(cy_q[k-1], IDX);
        dy = crp_pkg::shift_tz(cx_q[k-1], IDX);
        if (!cy_q[k-1][63]) begin
          cx_d = cx_q[k-1] + dx;
          cy_d = cy_q[k-1] - dy;
          z_d  = z_q[k-1] + ATAN;
        end else begin
          cx_d = cx_q[k-1] - dx;
          cy_d = cy_q[k-1] + dy;
          z_d  = z_q[k-1] - ATAN;
        end
      end
    end else begin : g_map
      // fold octant, swap and real sign into one add
      logic signed [63:0] oct;
      crp_pkg::flags_t    f;
      always_comb begin
        f    = flags_q[k-1];
        cx_d = cx_q[k-1];
        cy_d = cy_q[k-1];
        if (f.yzero) begin
          oct = '0;
        end else if (f.yeqx) begin
          oct = $signed(crp_pkg::QUARTER_PI);
        end else if (z_q[k-1][63]) begin
          oct = '0;
        end else begin
          oct = z_q[k-1];
        end
        unique case ({f.re_neg, f.sw})
          2'b00:   z_d = oct;
          2'b01:   z_d = $signed(crp_pkg::HALF_PI) - oct;
          2'b10:   z_d = $signed(crp_pkg::FULL_PI) - oct;
          default: z_d = $signed(crp_pkg::HALF_PI) + oct;
        endcase
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[k] <= cx_d;
        cy_q[k] <= cy_d;
        z_q[k]  <= z_d;
      end
    end
  end

  // ---------------- output register: round and sign ----------------
  logic [63:0]                       rsum;
  logic [crp_pkg::ANGLE_W-1:0]       rmag;
  logic signed [crp_pkg::ANGLE_W-1:0] ang_d;

  always_comb begin
    rsum = 64'(z_q[MAP_STG]) + (64'd1 << (RND_SH - 1));
    rmag = rsum[RND_SH +: crp_pkg::ANGLE_W];
    if (flags_q[MAP_STG].zero) begin
      ang_d = '0;
    end else if (flags_q[MAP_STG].im_neg) begin
      ang_d = $signed(crp_pkg::ANGLE_W'(0) - rmag);
    end else begin
      ang_d = $signed(rmag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[MAP_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= res_q[MAP_STG][DW-1:0];
      ang_q  <= ang_d;
      aval_q <= !flags_q[MAP_STG].zero;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.magnitude   = mag_q;
  assign out_o.angle       = ang_q;
  assign out_o.angle_valid = aval_q;

endmodule

>>> sv/crp_checker.sv
// ----------------------------------------------------------------------------
// crp_checker
// Port-level checks of the rectangular to polar core, bound to the top level.
// ----------------------------------------------------------------------------
module crp_checker #(
  parameter int DW = crp_pkg::DATA_WIDTH
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [DW-1:0]                      magnitude_i,
  input logic signed [crp_pkg::ANGLE_W-1:0] angle_i,
  input logic                               angle_valid_i
);

  localparam logic signed [crp_pkg::ANGLE_W-1:0] ANG_MAX = 16'sd25736;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(magnitude_i)
      && $stable(angle_i) && $stable(angle_valid_i))
    else $error("result item changed while stalled");

  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !angle_valid_i |-> angle_i == '0 && magnitude_i == '0)
    else $error("undefined angle with nonzero fields");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> angle_i <= ANG_MAX && angle_i >= -ANG_MAX)
    else $error("angle outside -pi..pi");

endmodule

bind complex_rect_to_polar_core crp_checker #(.DW(DATA_WIDTH)) u_crp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .magnitude_i   (out_o.magnitude),
  .angle_i       (out_o.angle),
  .angle_valid_i (out_o.angle_valid)
);
